// ----- rtl/mavg_pkg.sv -----
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared widths, defaults, controller states and the command/status bundles
// that pass between the moving-average controller and datapath.
// ----------------------------------------------------------------------------
package mavg_pkg;

	// Default sizing of the filter
	localparam int DEFAULT_CHANNELS = 8;
	localparam int DEFAULT_DEPTH    = 128;

	// Fixed field widths of the ports
	localparam int SAMPLE_W   = 16;
	localparam int CHAN_IN_W  = 3;
	localparam int WIDTH_IN_W = 8;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_FINISH
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture; // take the input beat, start the store read
		logic load;    // update channel state, write the store, arm the divider
		logic step;    // one divider iteration
		logic emit;    // move the quotient into the output register
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_last; // current divider iteration is the final one
	} dp_status_t;

endpackage

// ----- rtl/mavg_ram.sv -----
// ----------------------------------------------------------------------------
// mavg_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module mavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/mavg_ctrl.sv -----
// ----------------------------------------------------------------------------
// mavg_ctrl
// Sequencer for the moving-average filter: accepts one beat, steps the
// datapath through update and division, and owns the output valid flag.
// ----------------------------------------------------------------------------
module mavg_ctrl
	import mavg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	// State register and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands and handshake outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
			end
			ST_FINISH: begin
				// hold the result until the output register is free
				cmd.emit = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/mavg_dp.sv -----
// ----------------------------------------------------------------------------
// mavg_dp
// Datapath of the moving-average filter: per-channel sums, write positions,
// full flags and fill counts, the sample store, a bit-serial restoring
// divider and the output register.
// ----------------------------------------------------------------------------
module mavg_dp
	import mavg_pkg::*;
#(
	parameter int CHANNELS = DEFAULT_CHANNELS,
	parameter int DEPTH    = DEFAULT_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_status_t                 status,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [CHAN_IN_W-1:0]       channel,
	input  logic [WIDTH_IN_W-1:0]      window_width,
	output logic signed [SAMPLE_W-1:0] average
);

	localparam int PW = $clog2(DEPTH);                     // position index bits
	localparam int FW = PW + 1;                            // fill count bits
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW = SAMPLE_W + PW;                     // running sum bits
	localparam int NW = (FW > WIDTH_IN_W) ? FW : WIDTH_IN_W; // compare width
	localparam int AW = $clog2(CHANNELS * DEPTH);          // store address bits
	localparam int KW = $clog2(SW);                        // divider step count bits

	// Per-channel state
	logic signed [SW-1:0] sum_q  [CHANNELS];
	logic [PW-1:0]        pos_q  [CHANNELS];
	logic [FW-1:0]        fill_q [CHANNELS];
	logic [CHANNELS-1:0]  full_q;

	// Captured beat
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [CW-1:0]              ch_q;
	logic [WIDTH_IN_W-1:0]      width_q;

	// Divider
	logic [SW-1:0]         quo_q;
	logic [WIDTH_IN_W-1:0] rem_q;
	logic [WIDTH_IN_W-1:0] dvs_q;
	logic                  neg_q;
	logic [KW-1:0]         cnt_q;

	logic [SAMPLE_W-1:0] avg_q;

	// Input decode
	logic [CW-1:0]         ch_in;
	logic [WIDTH_IN_W-1:0] width_in;

	// Update stage
	logic [SAMPLE_W-1:0]  rdata;
	logic [AW-1:0]        raddr;
	logic [AW-1:0]        waddr;
	logic [PW-1:0]        pos_cur;
	logic [FW-1:0]        pos_inc;
	logic                 full_cur;
	logic signed [SAMPLE_W-1:0] oldest;
	logic signed [SW-1:0] sum_new;
	logic [SW-1:0]        sum_u;
	logic                 wrap;

	// Divider step
	logic [WIDTH_IN_W:0] rem_sh;
	logic [WIDTH_IN_W:0] trial;
	logic                fits;

	// Fold the channel number into range
	always_comb begin
		ch_in = '0;
		for (int i = 0; i < (1 << CHAN_IN_W); i++) begin
			if (channel == CHAN_IN_W'(i)) begin
				ch_in = CW'(i % CHANNELS);
			end
		end
	end

	// Clamp the window width to 1..DEPTH
	always_comb begin
		if (window_width == '0) begin
			width_in = WIDTH_IN_W'(1);
		end else if (NW'(window_width) > NW'(DEPTH)) begin
			width_in = WIDTH_IN_W'(DEPTH);
		end else begin
			width_in = window_width;
		end
	end

	// Store addresses: read at capture, write at load
	assign raddr = AW'(ch_in) * AW'(DEPTH) + AW'(pos_q[ch_in]);
	assign waddr = AW'(ch_q) * AW'(DEPTH) + AW'(pos_q[ch_q]);

	mavg_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(CHANNELS * DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.load),
		.waddr(waddr),
		.wdata(sample_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Channel update: entries past the fill count were never written and read as zero
	always_comb begin
		pos_cur  = pos_q[ch_q];
		full_cur = full_q[ch_q];
		pos_inc  = FW'(pos_cur) + FW'(1);
		oldest   = ({1'b0, pos_cur} < fill_q[ch_q]) ? signed'(rdata) : '0;
		sum_new  = sum_q[ch_q] + SW'(sample_q) - (full_cur ? SW'(oldest) : SW'(0));
		sum_u    = sum_new;
		wrap     = NW'(pos_inc) >= NW'(width_q);
	end

	// Per-channel state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				sum_q[c]  <= '0;
				pos_q[c]  <= '0;
				fill_q[c] <= '0;
			end
			full_q <= '0;
		end else if (cmd.load) begin
			sum_q[ch_q]  <= sum_new;
			pos_q[ch_q]  <= wrap ? '0 : pos_inc[PW-1:0];
			full_q[ch_q] <= full_cur | wrap;
			if (pos_inc > fill_q[ch_q]) begin
				fill_q[ch_q] <= pos_inc;
			end
		end
	end

	// Divider iteration: shift in one dividend bit, subtract if it fits
	always_comb begin
		rem_sh = {rem_q, quo_q[SW-1]};
		fits   = rem_sh >= {1'b0, dvs_q};
		trial  = rem_sh - {1'b0, dvs_q};
	end

	// Capture, load, divide and emit
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
			ch_q     <= ch_in;
			width_q  <= width_in;
		end
		if (cmd.load) begin
			neg_q <= sum_new[SW-1];
			quo_q <= sum_new[SW-1] ? (~sum_u + SW'(1)) : sum_u;
			rem_q <= '0;
			dvs_q <= full_cur ? width_q : WIDTH_IN_W'(pos_inc);
			cnt_q <= KW'(SW - 1);
		end else if (cmd.step) begin
			rem_q <= fits ? trial[WIDTH_IN_W-1:0] : rem_sh[WIDTH_IN_W-1:0];
			quo_q <= {quo_q[SW-2:0], fits};
			cnt_q <= cnt_q - KW'(1);
		end
		if (cmd.emit) begin
			avg_q <= neg_q ? (SAMPLE_W'(0) - quo_q[SAMPLE_W-1:0]) : quo_q[SAMPLE_W-1:0];
		end
	end

	assign status.div_last = (cnt_q == '0);
	assign average         = signed'(avg_q);

endmodule

// ----- rtl/multichannel_moving_average_top.sv -----
// ----------------------------------------------------------------------------
// multichannel_moving_average_top
// Per-channel moving-average filter with truncating division.
// ----------------------------------------------------------------------------
// One beat is processed at a time, and a new beat is accepted only after the
// previous one has gone through each step: capture the beat and read the sample
// store, update the channel and write the store, one divider step per running-sum
// bit in the bit-serial restoring divider, and load the output register once it
// is free. A new beat is accepted as soon as the previous one is in the output
// register, even if that result has not yet been taken. No clearing pass follows
// reset: per-channel fill counts make never-written store entries read as zero,
// so the block is ready right after reset.
// ----------------------------------------------------------------------------
module multichannel_moving_average_top
	import mavg_pkg::*;
#(
	parameter int CHANNELS = DEFAULT_CHANNELS,
	parameter int DEPTH    = DEFAULT_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [CHAN_IN_W-1:0]       channel,
	input  logic [WIDTH_IN_W-1:0]      window_width,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] average
);

	dp_cmd_t    cmd;
	dp_status_t status;

	mavg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mavg_dp #(
		.CHANNELS(CHANNELS),
		.DEPTH   (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.sample      (sample),
		.channel     (channel),
		.window_width(window_width),
		.average     (average)
	);

	// Never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result register overwritten while pending");

	// An accepted beat is loaded in the next cycle
	a_load_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (cmd.load && !in_ready))
		else $error("accepted beat not loaded");

	// Division starts right after the load
	a_div_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.step)
		else $error("divider not started after load");

	// At most one datapath command per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.load, cmd.step, cmd.emit}))
		else $error("conflicting datapath commands");

endmodule
